>>> rtl/lci_pkg.sv
// Shared types for the line / circle intersection pipeline.
// Holds the status codes and the flag group that travels with each transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lci_pkg;

    // result status reported with every transaction
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_HIT   = 2'd1,
        ST_ZERO_LEN = 2'd2
    } t_status;

    // per-stage control group: slot occupied, zero-length line, negative discriminant
    typedef struct packed {
        logic valid;
        logic degen;
        logic miss;
    } t_flags;

endpackage

`default_nettype wire

>>> rtl/lci_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// Stage one forms the partial products, stage two sums them.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lci_mul #(
    parameter int AW = 18,
    parameter int BW = 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0]   o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic signed [AH-1:0]    w_a_hi;
    logic        [AL-1:0]    w_a_lo;
    logic signed [BH-1:0]    w_b_hi;
    logic        [BL-1:0]    w_b_lo;
    logic signed [AH+BH-1:0] r_hh;
    logic signed [AH+BL:0]   r_hl;
    logic signed [AL+BH:0]   r_lh;
    logic        [AL+BL-1:0] r_ll;
    logic signed [PW-1:0]    n_p;
    logic signed [PW-1:0]    r_p;

    // split operands: signed upper half, unsigned lower half
    assign w_a_hi = i_a[AW-1:AL];
    assign w_a_lo = i_a[AL-1:0];
    assign w_b_hi = i_b[BW-1:BL];
    assign w_b_lo = i_b[BL-1:0];

    // recombine the partial products
    assign n_p = (PW'(r_hh) <<< (AL + BL)) + (PW'(r_hl) <<< AL)
               + (PW'(r_lh) <<< BL) + PW'($signed({1'b0, r_ll}));

    // partial products, then sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= w_a_hi * w_b_hi;
            r_hl <= w_a_hi * $signed({1'b0, w_b_lo});
            r_lh <= $signed({1'b0, w_a_lo}) * w_b_hi;
            r_ll <= w_a_lo * w_b_lo;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> rtl/lci_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// The radicand is RADW significant bits followed by ZW zero bits.
// Depends on lci_pkg for the flag group.
`timescale 1ns / 1ps
`default_nettype none

module lci_sqrt
    import lci_pkg::*;
#(
    parameter int RADW = 64,
    parameter int ZW   = 48,
    parameter int CW   = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_flags               i_flg,
    input  wire logic [RADW-1:0]      i_rad,
    input  wire logic [CW-1:0]        i_ctx,
    output t_flags                    o_flg,
    output logic [(RADW+ZW)/2-1:0]    o_root,
    output logic [CW-1:0]             o_ctx
);

    localparam int SW = (RADW + ZW) / 2;
    localparam int RW = SW + 2;

    logic [RW-1:0]   r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    logic [RADW-1:0] r_rad  [SW];
    logic [CW-1:0]   r_ctx  [SW];
    t_flags          r_flg  [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0]   w_rem;
        logic [SW-1:0]   w_root;
        logic [RADW-1:0] w_rad;
        logic [CW-1:0]   w_ctx;
        t_flags          w_flg;
        logic [RW+1:0]   w_rem4;
        logic [RW+1:0]   w_trial;
        logic [RW+1:0]   w_diff;
        logic            w_ge;
        logic [RW-1:0]   n_rem;
        logic [SW-1:0]   n_root;

        if (k == 0) begin : g_in
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
            assign w_ctx  = i_ctx;
            assign w_flg  = i_flg;
        end else begin : g_chain
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_ctx  = r_ctx[k-1];
            assign w_flg  = r_flg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign w_rem4  = {w_rem, w_rad[RADW-1 -: 2]};
        assign w_trial = {{(RW - SW){1'b0}}, w_root, 2'b01};
        assign w_diff  = w_rem4 - w_trial;
        assign w_ge    = (w_rem4 >= w_trial);
        assign n_rem   = w_ge ? w_diff[RW-1:0] : w_rem4[RW-1:0];
        assign n_root  = {w_root[SW-2:0], w_ge};

        // advance the control flags
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flg[k] <= '0;
            end else if (i_en) begin
                r_flg[k] <= w_flg;
            end
        end

        // advance the data
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {w_rad[RADW-3:0], 2'b00};
                r_ctx[k]  <= w_ctx;
            end
        end
    end

    assign o_flg  = r_flg[SW-1];
    assign o_root = r_root[SW-1];
    assign o_ctx  = r_ctx[SW-1];

endmodule

`default_nettype wire

>>> rtl/lci_div.sv
// Pipelined two-lane rounded divider: mu = floor((2*n + a) / (2*a)) for two
// numerators sharing one denominator, one quotient bit per stage.
// Depends on lci_pkg for the flag group.
`timescale 1ns / 1ps
`default_nettype none

module lci_div
    import lci_pkg::*;
#(
    parameter int NW = 59,
    parameter int AW = 33,
    parameter int CW = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_flags               i_flg,
    input  wire logic signed [NW-1:0] i_n1,
    input  wire logic signed [NW-1:0] i_n2,
    input  wire logic [AW-1:0]        i_a,
    input  wire logic [CW-1:0]        i_ctx,
    output t_flags                    o_flg,
    output logic signed [NW+1:0]      o_mu1,
    output logic signed [NW+1:0]      o_mu2,
    output logic [CW-1:0]             o_ctx
);

    localparam int TW  = NW + 2;
    localparam int QW  = NW + 1;
    localparam int DNW = AW + 1;
    localparam int MUW = NW + 2;

    logic signed [TW-1:0] r_p1_t [2];
    logic [DNW-1:0]       r_p1_den;
    logic [CW-1:0]        r_p1_ctx;
    t_flags               r_p1_flg;

    logic [QW-1:0]        r_p2_num [2];
    logic                 r_p2_neg [2];
    logic [DNW-1:0]       r_p2_den;
    logic [CW-1:0]        r_p2_ctx;
    t_flags               r_p2_flg;

    logic [QW-1:0]        r_num [QW][2];
    logic [DNW-1:0]       r_rem [QW][2];
    logic [QW-1:0]        r_q   [QW][2];
    logic                 r_neg [QW][2];
    logic [DNW-1:0]       r_den [QW];
    logic [CW-1:0]        r_ctx [QW];
    t_flags               r_flg [QW];

    logic signed [MUW-1:0] r_mu [2];
    logic [CW-1:0]         r_o_ctx;
    t_flags                r_o_flg;

    logic signed [NW-1:0]  w_n [2];

    assign w_n[0] = i_n1;
    assign w_n[1] = i_n2;

    // control flags of the front and back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_flg <= '0;
            r_p2_flg <= '0;
            r_o_flg  <= '0;
        end else if (i_en) begin
            r_p1_flg <= i_flg;
            r_p2_flg <= r_p1_flg;
            r_o_flg  <= r_flg[QW-1];
        end
    end

    // form 2n+a, fold negative dividends to a magnitude, then restore sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_p1_t[l]   <= (TW'(w_n[l]) <<< 1) + TW'($signed({1'b0, i_a}));
                r_p2_neg[l] <= r_p1_t[l][TW-1];
                r_p2_num[l] <= r_p1_t[l][TW-1] ? QW'(~r_p1_t[l]) + QW'(r_p1_den)
                                               : QW'(r_p1_t[l]);
                r_mu[l]     <= r_neg[QW-1][l] ? -$signed(MUW'(r_q[QW-1][l]))
                                              : $signed(MUW'(r_q[QW-1][l]));
            end
            r_p1_den <= {i_a, 1'b0};
            r_p1_ctx <= i_ctx;
            r_p2_den <= r_p1_den;
            r_p2_ctx <= r_p1_ctx;
            r_o_ctx  <= r_ctx[QW-1];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [QW-1:0]  w_num [2];
        logic [DNW-1:0] w_rem [2];
        logic [QW-1:0]  w_q   [2];
        logic           w_neg [2];
        logic [DNW-1:0] w_den;
        logic [CW-1:0]  w_ctx;
        t_flags         w_flg;
        logic [DNW:0]   w_rem2 [2];
        logic [DNW:0]   w_diff [2];
        logic           w_ge   [2];

        if (k == 0) begin : g_in
            assign w_num    = r_p2_num;
            assign w_neg    = r_p2_neg;
            assign w_rem[0] = '0;
            assign w_rem[1] = '0;
            assign w_q[0]   = '0;
            assign w_q[1]   = '0;
            assign w_den    = r_p2_den;
            assign w_ctx    = r_p2_ctx;
            assign w_flg    = r_p2_flg;
        end else begin : g_chain
            assign w_num = r_num[k-1];
            assign w_neg = r_neg[k-1];
            assign w_rem = r_rem[k-1];
            assign w_q   = r_q[k-1];
            assign w_den = r_den[k-1];
            assign w_ctx = r_ctx[k-1];
            assign w_flg = r_flg[k-1];
        end

        // shift in the next dividend bit and try a subtract
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_rem2[l] = {w_rem[l], w_num[l][QW-1]};
                w_diff[l] = w_rem2[l] - {1'b0, w_den};
                w_ge[l]   = (w_rem2[l] >= {1'b0, w_den});
            end
        end

        // advance the control flags
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flg[k] <= '0;
            end else if (i_en) begin
                r_flg[k] <= w_flg;
            end
        end

        // advance remainders and quotients
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[k][l] <= w_ge[l] ? w_diff[l][DNW-1:0] : w_rem2[l][DNW-1:0];
                    r_q[k][l]   <= {w_q[l][QW-2:0], w_ge[l]};
                    r_num[k][l] <= {w_num[l][QW-2:0], 1'b0};
                    r_neg[k][l] <= w_neg[l];
                end
                r_den[k] <= w_den;
                r_ctx[k] <= w_ctx;
            end
        end
    end

    assign o_flg = r_o_flg;
    assign o_mu1 = r_mu[0];
    assign o_mu2 = r_mu[1];
    assign o_ctx = r_o_ctx;

endmodule

`default_nettype wire

>>> rtl/line_circle_intersection.sv
// Line / circle intersection, fully pipelined: one transaction may enter every
// cycle while o_stall is low, and each gives exactly one result, in order. Most
// of the pipeline's depth is set by the bit-per-stage square root and the
// bit-per-stage divider. A stall on the output freezes the whole pipeline and is
// passed back on o_stall. Status 2 marks a zero-length line, status 1 a miss;
// both return a zero point. Otherwise the point is rounded to nearest and
// saturated to the coordinate range.
// Depends on lci_pkg, lci_mul, lci_sqrt and lci_div.
`timescale 1ns / 1ps
`default_nettype none

module line_circle_intersection
    import lci_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int ROOT_FRAC_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic [COORD_WIDTH-2:0]        i_radius,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0]      o_hit_x,
    output logic signed [COORD_WIDTH-1:0]      o_hit_y,
    output logic [1:0]                         o_status
);

    localparam int W     = COORD_WIDTH;
    localparam int R     = ROOT_FRAC_BITS;
    localparam int DW    = W + 1;
    localparam int PW1   = 2 * W + 2;
    localparam int AW    = 2 * W + 1;
    localparam int HW    = 2 * W + 2;
    localparam int R2W   = 2 * W - 2;
    localparam int AR2W  = AW + R2W + 2;
    localparam int QQW   = 2 * HW;
    localparam int RADW  = 4 * W;
    localparam int SW    = 2 * W + R;
    localparam int NW    = 2 * W + R + 3;
    localparam int MUW   = NW + 2;
    localparam int PRW   = MUW + DW;
    localparam int PLW   = PRW + 1 - R;
    localparam int CTX2W = 3 * W + 2 * DW;
    localparam int CTX1W = HW + AW + CTX2W;
    localparam logic [PRW:0] ROUND_HALF = {{(PRW + 1 - R){1'b0}}, 1'b1, {(R - 1){1'b0}}};

    logic w_adv;

    // front end
    t_flags                r_s0_flg;
    logic signed [DW-1:0]  r_s0_dx, r_s0_dy, r_s0_px, r_s0_py;
    logic [W-2:0]          r_s0_r;
    logic signed [W-1:0]   r_s0_sx, r_s0_sy, r_s0_ey;

    t_flags                r_s1_flg;
    logic signed [PW1-1:0] r_s1_dxdx, r_s1_dydy, r_s1_dxpx, r_s1_dypy, r_s1_dxpy, r_s1_dypx;
    logic [R2W-1:0]        r_s1_r2;
    logic signed [W-1:0]   r_s1_sx, r_s1_sy, r_s1_ey;
    logic signed [DW-1:0]  r_s1_dx, r_s1_dy;

    t_flags                r_s2_flg;
    logic [AW-1:0]         r_s2_a;
    logic signed [HW-1:0]  r_s2_h, r_s2_q;
    logic [R2W-1:0]        r_s2_r2;
    logic signed [W-1:0]   r_s2_sx, r_s2_sy, r_s2_ey;
    logic signed [DW-1:0]  r_s2_dx, r_s2_dy;
    logic [CTX1W-1:0]      w_s2_ctx;

    t_flags                r_s3_flg, r_s4_flg, r_s5_flg;
    logic [CTX1W-1:0]      r_s3_ctx, r_s4_ctx, r_s5_ctx;
    logic signed [AR2W-1:0] w_ar2;
    logic signed [QQW-1:0] w_qq;
    logic signed [QQW-1:0] w_disc;
    logic [RADW-1:0]       r_s5_rad;

    // square root and roots
    t_flags                w_sq_flg;
    logic [SW-1:0]         w_sq_root;
    logic [CTX1W-1:0]      w_sq_ctx;
    logic signed [HW-1:0]  w_sq_h;
    logic signed [NW-1:0]  w_hs;
    logic signed [NW-1:0]  w_sroot;

    t_flags                r_s6_flg;
    logic signed [NW-1:0]  r_s6_n1, r_s6_n2;
    logic [AW-1:0]         r_s6_a;
    logic [CTX2W-1:0]      r_s6_ctx;

    t_flags                w_dv_flg;
    logic signed [MUW-1:0] w_mu1, w_mu2;
    logic [CTX2W-1:0]      w_dv_ctx;
    logic signed [DW-1:0]  w_dv_dx, w_dv_dy;

    // point placement
    logic signed [PRW-1:0] w_px1, w_px2, w_py1, w_py2;
    t_flags                r_pd1_flg, r_pd2_flg;
    logic [CTX2W-1:0]      r_pd1_ctx, r_pd2_ctx;
    logic signed [W-1:0]   w_pd_sx, w_pd_sy, w_pd_ey;

    t_flags                r_pl_flg;
    logic signed [PLW-1:0] r_pl_x1, r_pl_x2, r_pl_y1, r_pl_y2;
    logic signed [W-1:0]   r_pl_sy, r_pl_ey;

    // selection and output register
    logic signed [PLW-1:0] w_sy_l, w_ey_l;
    logic                  w_between;
    logic signed [W-1:0]   n_hit_x, n_hit_y;
    t_status               n_status;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_out_hit_x, r_out_hit_y;
    t_status               r_out_status;

    // round half up at the root fraction point
    function automatic logic signed [PLW-1:0] f_place(input logic signed [W-1:0] base,
                                                      input logic signed [PRW-1:0] prod);
        logic signed [PRW:0] v;
        logic signed [PRW:0] s;
        v = ((PRW + 1)'(base) <<< R) + (PRW + 1)'(prod) + $signed(ROUND_HALF);
        s = v >>> R;
        return s[PLW-1:0];
    endfunction

    // clamp to the coordinate range
    function automatic logic signed [W-1:0] f_sat(input logic signed [PLW-1:0] v);
        logic [PLW-W:0] top;
        top = v[PLW-1:W-1];
        if (&top || ~|top) begin
            return v[W-1:0];
        end else if (v[PLW-1]) begin
            return {1'b1, {(W - 1){1'b0}}};
        end else begin
            return {1'b0, {(W - 1){1'b1}}};
        end
    endfunction

    // the whole pipeline holds while a finished result waits
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    assign w_s2_ctx = {r_s2_h, r_s2_a, r_s2_sx, r_s2_sy, r_s2_ey, r_s2_dx, r_s2_dy};

    // a*r^2 and q^2
    lci_mul #(.AW(AW + 1), .BW(R2W + 1)) u_mul_ar2 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   ($signed({1'b0, r_s2_a})),
        .i_b   ($signed({1'b0, r_s2_r2})),
        .o_p   (w_ar2)
    );

    lci_mul #(.AW(HW), .BW(HW)) u_mul_qq (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_s2_q),
        .i_b   (r_s2_q),
        .o_p   (w_qq)
    );

    assign w_disc = QQW'(w_ar2) - w_qq;

    lci_sqrt #(.RADW(RADW), .ZW(2 * R), .CW(CTX1W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_flg   (r_s5_flg),
        .i_rad   (r_s5_rad),
        .i_ctx   (r_s5_ctx),
        .o_flg   (w_sq_flg),
        .o_root  (w_sq_root),
        .o_ctx   (w_sq_ctx)
    );

    // -h * 2^R plus or minus the root
    assign w_sq_h = w_sq_ctx[CTX1W-1 -: HW];
    assign w_hs   = -(NW'(w_sq_h) <<< R);
    assign w_sroot = NW'(w_sq_root);

    lci_div #(.NW(NW), .AW(AW), .CW(CTX2W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_flg   (r_s6_flg),
        .i_n1    (r_s6_n1),
        .i_n2    (r_s6_n2),
        .i_a     (r_s6_a),
        .i_ctx   (r_s6_ctx),
        .o_flg   (w_dv_flg),
        .o_mu1   (w_mu1),
        .o_mu2   (w_mu2),
        .o_ctx   (w_dv_ctx)
    );

    assign w_dv_dx = w_dv_ctx[2*DW-1 -: DW];
    assign w_dv_dy = w_dv_ctx[DW-1:0];

    // mu * d for both roots and both axes
    lci_mul #(.AW(MUW), .BW(DW)) u_mul_x1 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_mu1), .i_b (w_dv_dx), .o_p (w_px1)
    );
    lci_mul #(.AW(MUW), .BW(DW)) u_mul_x2 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_mu2), .i_b (w_dv_dx), .o_p (w_px2)
    );
    lci_mul #(.AW(MUW), .BW(DW)) u_mul_y1 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_mu1), .i_b (w_dv_dy), .o_p (w_py1)
    );
    lci_mul #(.AW(MUW), .BW(DW)) u_mul_y2 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_mu2), .i_b (w_dv_dy), .o_p (w_py2)
    );

    assign w_pd_sx = r_pd2_ctx[CTX2W-1 -: W];
    assign w_pd_sy = r_pd2_ctx[CTX2W-W-1 -: W];
    assign w_pd_ey = r_pd2_ctx[CTX2W-2*W-1 -: W];

    // pick the first root when its y lies between the line's end points
    assign w_sy_l = PLW'(r_pl_sy);
    assign w_ey_l = PLW'(r_pl_ey);
    assign w_between = (w_sy_l >= r_pl_y1 && r_pl_y1 >= w_ey_l)
                    || (w_ey_l >= r_pl_y1 && r_pl_y1 >= w_sy_l);

    always_comb begin
        n_hit_x  = '0;
        n_hit_y  = '0;
        n_status = ST_OK;
        if (r_pl_flg.degen) begin
            n_status = ST_ZERO_LEN;
        end else if (r_pl_flg.miss) begin
            n_status = ST_NO_HIT;
        end else if (w_between) begin
            n_hit_x = f_sat(r_pl_x1);
            n_hit_y = f_sat(r_pl_y1);
        end else begin
            n_hit_x = f_sat(r_pl_x2);
            n_hit_y = f_sat(r_pl_y2);
        end
    end

    // advance the valid and status flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_flg    <= '0;
            r_s1_flg    <= '0;
            r_s2_flg    <= '0;
            r_s3_flg    <= '0;
            r_s4_flg    <= '0;
            r_s5_flg    <= '0;
            r_s6_flg    <= '0;
            r_pd1_flg   <= '0;
            r_pd2_flg   <= '0;
            r_pl_flg    <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_flg.valid <= i_valid;
            r_s0_flg.degen <= (i_end_x == i_start_x) && (i_end_y == i_start_y);
            r_s0_flg.miss  <= 1'b0;
            r_s1_flg       <= r_s0_flg;
            r_s2_flg       <= r_s1_flg;
            r_s3_flg       <= r_s2_flg;
            r_s4_flg       <= r_s3_flg;
            r_s5_flg.valid <= r_s4_flg.valid;
            r_s5_flg.degen <= r_s4_flg.degen;
            r_s5_flg.miss  <= w_disc[QQW-1];
            r_s6_flg       <= w_sq_flg;
            r_pd1_flg      <= w_dv_flg;
            r_pd2_flg      <= r_pd1_flg;
            r_pl_flg       <= r_pd2_flg;
            r_out_valid    <= r_pl_flg.valid;
        end
    end

    // advance the datapath
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // differences to the line direction and to the centre
            r_s0_dx <= DW'(i_end_x) - DW'(i_start_x);
            r_s0_dy <= DW'(i_end_y) - DW'(i_start_y);
            r_s0_px <= DW'(i_start_x) - DW'(i_center_x);
            r_s0_py <= DW'(i_start_y) - DW'(i_center_y);
            r_s0_r  <= i_radius;
            r_s0_sx <= i_start_x;
            r_s0_sy <= i_start_y;
            r_s0_ey <= i_end_y;

            // products
            r_s1_dxdx <= r_s0_dx * r_s0_dx;
            r_s1_dydy <= r_s0_dy * r_s0_dy;
            r_s1_dxpx <= r_s0_dx * r_s0_px;
            r_s1_dypy <= r_s0_dy * r_s0_py;
            r_s1_dxpy <= r_s0_dx * r_s0_py;
            r_s1_dypx <= r_s0_dy * r_s0_px;
            r_s1_r2   <= r_s0_r * r_s0_r;
            r_s1_sx   <= r_s0_sx;
            r_s1_sy   <= r_s0_sy;
            r_s1_ey   <= r_s0_ey;
            r_s1_dx   <= r_s0_dx;
            r_s1_dy   <= r_s0_dy;

            // a = |d|^2, h = d.p, q = d x p
            r_s2_a  <= AW'(r_s1_dxdx + r_s1_dydy);
            r_s2_h  <= r_s1_dxpx + r_s1_dypy;
            r_s2_q  <= r_s1_dxpy - r_s1_dypx;
            r_s2_r2 <= r_s1_r2;
            r_s2_sx <= r_s1_sx;
            r_s2_sy <= r_s1_sy;
            r_s2_ey <= r_s1_ey;
            r_s2_dx <= r_s1_dx;
            r_s2_dy <= r_s1_dy;

            // hold context beside the multipliers, then take the discriminant
            r_s3_ctx <= w_s2_ctx;
            r_s4_ctx <= r_s3_ctx;
            r_s5_ctx <= r_s4_ctx;
            r_s5_rad <= w_disc[RADW-1:0];

            // numerators of both roots
            r_s6_n1  <= w_hs + w_sroot;
            r_s6_n2  <= w_hs - w_sroot;
            r_s6_a   <= w_sq_ctx[CTX1W-HW-1 -: AW];
            r_s6_ctx <= w_sq_ctx[CTX2W-1:0];

            // hold context beside the placement multipliers
            r_pd1_ctx <= w_dv_ctx;
            r_pd2_ctx <= r_pd1_ctx;

            // candidate points
            r_pl_x1 <= f_place(w_pd_sx, w_px1);
            r_pl_x2 <= f_place(w_pd_sx, w_px2);
            r_pl_y1 <= f_place(w_pd_sy, w_py1);
            r_pl_y2 <= f_place(w_pd_sy, w_py2);
            r_pl_sy <= w_pd_sy;
            r_pl_ey <= w_pd_ey;

            // result
            r_out_hit_x  <= n_hit_x;
            r_out_hit_y  <= n_hit_y;
            r_out_status <= n_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_hit_x  = r_out_hit_x;
    assign o_hit_y  = r_out_hit_y;
    assign o_status = r_out_status;

endmodule

`default_nettype wire

>>> dv/lci_checker.sv
// Checker for the line / circle intersection pipeline: watches both channels,
// predicts each result from the accepted query and compares in order.
// Depends on lci_pkg.
`timescale 1ns / 1ps

module lci_checker
    import lci_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               o_stall,
    input  wire logic signed [15:0] i_start_x,
    input  wire logic signed [15:0] i_start_y,
    input  wire logic signed [15:0] i_end_x,
    input  wire logic signed [15:0] i_end_y,
    input  wire logic signed [15:0] i_center_x,
    input  wire logic signed [15:0] i_center_y,
    input  wire logic [14:0]        i_radius,
    input  wire logic               o_valid,
    input  wire logic               i_stall,
    input  wire logic signed [15:0] o_hit_x,
    input  wire logic signed [15:0] o_hit_y,
    input  wire logic [1:0]         o_status,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_hits,
    output int                      o_misses,
    output int                      o_zero_len
);

    localparam int RF = 24;
    typedef logic signed [159:0] t_big;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        t_status            st;
    } t_hit;

    t_hit hit_queue[$];

    // floor of (2*num + a) / (2*a), a positive
    function automatic t_big div_nearest(t_big num, t_big a);
        t_big t, den;
        t   = 2 * num + a;
        den = 2 * a;
        if (t >= 0)
            return t / den;
        return -((-t + den - 1) / den);
    endfunction

    // point coordinate on the line at parameter mu, rounded to nearest
    function automatic t_big line_point(t_big base, t_big mu, t_big d);
        t_big v;
        v = (base <<< RF) + mu * d + (t_big'(1) <<< (RF - 1));
        return v >>> RF;
    endfunction

    function automatic logic signed [15:0] clamp16(t_big v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic t_hit solve_hit(logic signed [15:0] sx, logic signed [15:0] sy,
                                       logic signed [15:0] ex, logic signed [15:0] ey,
                                       logic signed [15:0] cx, logic signed [15:0] cy,
                                       logic [14:0] rad);
        t_hit res;
        t_big dx, dy, px, py, r, a, h, q, disc, n, s, c, mu1, mu2, y1, hx, hy;
        t_big bsx, bsy, bey;
        bsx = sx; bsy = sy; bey = ey;
        dx  = t_big'(ex) - bsx;
        dy  = bey - bsy;
        px  = bsx - t_big'(cx);
        py  = bsy - t_big'(cy);
        r   = {145'd0, rad};
        res = '{x: '0, y: '0, st: ST_OK};
        a   = dx * dx + dy * dy;
        if (a == 0) begin
            res.st = ST_ZERO_LEN;
            return res;
        end
        h    = dx * px + dy * py;
        q    = dx * py - dy * px;
        disc = a * r * r - q * q;
        if (disc < 0) begin
            res.st = ST_NO_HIT;
            return res;
        end
        // bitwise floor square root of the scaled discriminant
        n = disc <<< (2 * RF);
        s = 0;
        for (int i = 70; i >= 0; i--) begin
            c = s | (t_big'(1) <<< i);
            if (c * c <= n)
                s = c;
        end
        mu1 = div_nearest(-(h <<< RF) + s, a);
        mu2 = div_nearest(-(h <<< RF) - s, a);
        y1  = line_point(bsy, mu1, dy);
        if ((bsy >= y1 && y1 >= bey) || (bey >= y1 && y1 >= bsy)) begin
            hx = line_point(bsx, mu1, dx);
            hy = y1;
        end else begin
            hx = line_point(bsx, mu2, dx);
            hy = line_point(bsy, mu2, dy);
        end
        res.x = clamp16(hx);
        res.y = clamp16(hy);
        return res;
    endfunction

    assign o_pending = hit_queue.size();

    // predict on each accepted query, compare on each accepted result
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            o_errors   <= 0;
            o_checked  <= 0;
            o_hits     <= 0;
            o_misses   <= 0;
            o_zero_len <= 0;
        end else begin
            if (i_valid && !o_stall)
                hit_queue = {hit_queue, solve_hit(i_start_x, i_start_y, i_end_x, i_end_y,
                                                  i_center_x, i_center_y, i_radius)};
            if (o_valid && !i_stall) begin
                o_checked <= o_checked + 1;
                if (hit_queue.size() == 0) begin
                    $error("result with nothing outstanding: x=%0d y=%0d status=%0d",
                           o_hit_x, o_hit_y, o_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hit_queue.pop_front();
                    case (want.st)
                        ST_OK:       o_hits <= o_hits + 1;
                        ST_NO_HIT:   o_misses <= o_misses + 1;
                        default:     o_zero_len <= o_zero_len + 1;
                    endcase
                    if (o_hit_x !== want.x || o_hit_y !== want.y
                            || o_status !== want.st) begin
                        if (o_hit_x !== want.x)
                            $error("hit_x: expected %0d, got %0d", want.x, o_hit_x);
                        if (o_hit_y !== want.y)
                            $error("hit_y: expected %0d, got %0d", want.y, o_hit_y);
                        if (o_status !== want.st)
                            $error("status: expected %0d, got %0d", want.st, o_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> dv/tb_line_circle_intersection.sv
// Top of the line / circle intersection testbench: clock, reset, query stimulus,
// result back-pressure and the verdict. Depends on lci_pkg, lci_checker and the DUT.
`timescale 1ns / 1ps

module tb_line_circle_intersection;
    import lci_pkg::*;

    localparam int N_RANDOM  = 1730;
    localparam int WD_LIMIT  = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_start_x, i_start_y, i_end_x, i_end_y, i_center_x, i_center_y;
    logic [14:0]        i_radius;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_hit_x, o_hit_y;
    logic [1:0]         o_status;
    int                 errors, pending, checked, n_hits, n_misses, n_zero;
    int                 sent;
    logic               quiet;
    logic               hold_req;

    line_circle_intersection u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_end_x(i_end_x),
        .i_end_y(i_end_y), .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_radius(i_radius), .o_valid(o_valid), .i_stall(i_stall),
        .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_status(o_status)
    );

    lci_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_end_x(i_end_x),
        .i_end_y(i_end_y), .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_radius(i_radius), .o_valid(o_valid), .i_stall(i_stall),
        .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_status(o_status),
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_hits(n_hits), .o_misses(n_misses), .o_zero_len(n_zero)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stall the result side in bursts; hold off for a long stretch on request
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // stop the run when nothing moves on either channel for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle = 0;
            else
                idle++;
            if (idle >= WD_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // offer one query and hold it until the pipeline takes it
    task automatic send_query(input logic signed [15:0] sx, sy, ex, ey, cx, cy,
                              input logic [14:0] rad);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= rad;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    function automatic logic signed [15:0] near_coord(int base, int span);
        int v;
        v = base + $signed($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // directed corners, then random queries mostly aimed at the circle
    initial begin
        int cx, cy, rad, span;
        i_valid = 1'b0;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        i_center_x = '0; i_center_y = '0; i_radius = '0;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length lines, including at the extremes
        send_query(16'sd100, -16'sd50, 16'sd100, -16'sd50, 0, 0, 15'd100);
        send_query(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0, 15'h7fff);
        // clean secant, tangent, miss
        send_query(-16'sd800, 0, 16'sd800, 0, 0, 0, 15'd320);
        send_query(-16'sd100, 16'sd160, 16'sd100, 16'sd160, 0, 0, 15'd160);
        send_query(-16'sd100, 16'sd500, 16'sd100, 16'sd500, 0, 0, 15'd160);
        send_query(0, -16'sd800, 0, 16'sd800, 16'sd20, 0, 15'd64);
        // zero radius through and beside the centre
        send_query(-16'sd50, -16'sd50, 16'sd50, 16'sd50, 0, 0, 15'd0);
        send_query(-16'sd50, -16'sd49, 16'sd50, 16'sd51, 0, 0, 15'd0);
        // field extremes and saturating points
        send_query(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                   -16'sd32768, 16'sd32767, 15'h7fff);
        send_query(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                   16'sd32767, 16'sd32767, 15'h7fff);
        send_query(16'sd32767, -16'sd32768, 16'sd32766, -16'sd32768, 0, 0, 15'h7fff);
        send_query(0, 0, 16'sd1, 0, -16'sd32768, -16'sd32768, 15'h7fff);
        send_query(-16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd32767, 16'sd32767, 15'h5555);
        send_query(16'sd10, 16'sd10, 16'sd11, 16'sd30, -16'sd3, 16'sd7, 15'h2aaa);
        // short segment inside the circle: root beyond the end points
        send_query(-16'sd1, 16'sd3, 16'sd2, -16'sd2, 0, 0, 15'd1000);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 400)
                hold_req = 1'b1;
            if (k == 900) begin
                // drop valid and let everything outstanding drain
                i_valid <= 1'b0;
                wait (pending == 0);
            end
            if (k == N_RANDOM - 250)
                quiet = 1'b1;
            if ($urandom_range(0, 9) < 3) begin
                send_query(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 15'($urandom));
            end else begin
                span = ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(1, 2000);
                rad  = $urandom_range(0, span);
                cx   = $signed($urandom_range(0, 65535)) - 32768;
                cy   = $signed($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1)) begin
                    cx = cx / 16;
                    cy = cy / 16;
                end
                send_query(near_coord(cx, 2 * rad + 2), near_coord(cy, 2 * rad + 2),
                           near_coord(cx, 2 * rad + 2), near_coord(cy, 2 * rad + 2),
                           cx[15:0], cy[15:0], rad[14:0]);
            end
        end
        i_valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d queries, checked %0d results: %0d hits, %0d misses, %0d zero-length.",
                 sent, checked, n_hits, n_misses, n_zero);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
